FILE: design/b64enc_pkg.sv
// Shared types, constants and the character mapping of the base64 encoder.
package b64enc_pkg;

   localparam int B64_QUEUE_DEPTH = 2;
   localparam logic [6:0] PAD_CHAR = 7'h3D;

   typedef enum logic [1:0] {
      PHASE_0 = 2'd0,
      PHASE_1 = 2'd1,
      PHASE_2 = 2'd2
   } phase_type;

   typedef struct packed {
      logic [3:0][6:0] chars;
      logic [1:0]      last_idx;
      logic            end_mark;
   } entry_type;

   typedef struct packed {
      logic empty;
      logic full;
   } q_stat_type;

   function automatic logic [6:0] sextet_char(input logic [5:0] v);
      logic [6:0] ch;
      case (v) inside
         [6'd0:6'd25]: begin
            ch = 7'h41 + {1'b0, v};
         end
         [6'd26:6'd51]: begin
            ch = 7'h61 + {1'b0, v} - 7'd26;
         end
         [6'd52:6'd61]: begin
            ch = 7'h30 + {1'b0, v} - 7'd52;
         end
         6'd62: begin
            ch = 7'h2B;
         end
         default: begin
            ch = 7'h2F;
         end
      endcase
      return ch;
   endfunction

endpackage

FILE: design/b64enc_front.sv
// Front end: accepts bytes, tracks the group phase and builds character entries.
module b64enc_front import b64enc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_final_byte,
   input  q_stat_type q_stat,
   output logic       push,
   output entry_type  push_entry
);

   phase_type  phase_ff;
   phase_type  phase_in;
   logic [3:0] left_ff;
   logic [3:0] left_in;

   assign req_ready = !q_stat.full;
   assign push      = req_valid && req_ready;

   always_comb begin
      phase_in = phase_ff;
      left_in  = left_ff;
      if (push) begin
         case (phase_ff)
            PHASE_1: begin
               phase_in = PHASE_2;
               left_in  = req_data_byte[3:0];
            end
            PHASE_2: begin
               phase_in = PHASE_0;
               left_in  = 4'd0;
            end
            default: begin
               phase_in = PHASE_1;
               left_in  = {2'b00, req_data_byte[1:0]};
            end
         endcase
         if (req_final_byte) begin
            phase_in = PHASE_0;
            left_in  = 4'd0;
         end
      end
   end

   always_comb begin
      push_entry.chars    = {4{PAD_CHAR}};
      push_entry.last_idx = 2'd0;
      push_entry.end_mark = 1'b0;
      case (phase_ff)
         PHASE_1: begin
            push_entry.chars[0] = sextet_char({left_ff[1:0], req_data_byte[7:4]});
            if (req_final_byte) begin
               push_entry.chars[1] = sextet_char({req_data_byte[3:0], 2'b00});
               push_entry.last_idx = 2'd2;
               push_entry.end_mark = 1'b1;
            end
         end
         PHASE_2: begin
            push_entry.chars[0] = sextet_char({left_ff, req_data_byte[7:6]});
            push_entry.chars[1] = sextet_char(req_data_byte[5:0]);
            push_entry.last_idx = 2'd1;
            push_entry.end_mark = req_final_byte;
         end
         default: begin
            push_entry.chars[0] = sextet_char(req_data_byte[7:2]);
            if (req_final_byte) begin
               push_entry.chars[1] = sextet_char({req_data_byte[1:0], 4'b0000});
               push_entry.last_idx = 2'd3;
               push_entry.end_mark = 1'b1;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_0;
         left_ff  <= 4'd0;
      end else begin
         phase_ff <= phase_in;
         left_ff  <= left_in;
      end
   end

endmodule

FILE: design/b64enc_queue.sv
// Short queue of character entries between the front end and the back end.
module b64enc_queue import b64enc_pkg::*; #(
   parameter int QUEUE_DEPTH = B64_QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  entry_type  push_entry,
   input  logic       pop,
   output entry_type  head,
   output q_stat_type q_stat
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   entry_type              entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff;
   logic [PTR_W-1:0]       wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff;
   logic [PTR_W-1:0]       rd_ptr_in;
   logic [CNT_W-1:0]       count_ff;
   logic [CNT_W-1:0]       count_in;

   assign head         = entries_ff[rd_ptr_ff];
   assign q_stat.empty = (count_ff == '0);
   assign q_stat.full  = (count_ff == CNT_W'(QUEUE_DEPTH));

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10: begin
            count_in = count_ff + 1'b1;
         end
         2'b01: begin
            count_in = count_ff - 1'b1;
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: design/b64enc_back.sv
// Back end: serializes queued entries into one character per transaction.
module b64enc_back import b64enc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  entry_type  head,
   input  q_stat_type q_stat,
   output logic       pop,
   output logic [1:0] char_idx,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [6:0] rsp_code_char,
   output logic       rsp_end_mark
);

   logic [1:0] idx_ff;
   logic [1:0] idx_in;
   logic       valid_ff;
   logic       valid_in;
   logic [6:0] char_ff;
   logic [6:0] char_in;
   logic       mark_ff;
   logic       mark_in;
   logic       load;
   logic       at_last;

   assign at_last = (idx_ff == head.last_idx);
   assign load    = !q_stat.empty && (!valid_ff || rsp_ready);
   assign pop     = load && at_last;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      char_in  = char_ff;
      mark_in  = mark_ff;
      if (load) begin
         valid_in = 1'b1;
         char_in  = head.chars[idx_ff];
         mark_in  = head.end_mark && at_last;
         idx_in   = at_last ? 2'd0 : idx_ff + 2'd1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
      mark_ff <= mark_in;
   end

   assign char_idx      = idx_ff;
   assign rsp_valid     = valid_ff;
   assign rsp_code_char = char_ff;
   assign rsp_end_mark  = mark_ff;

endmodule

FILE: design/base64_stream_encoder.sv
// Top level of the streaming base64 encoder.
// Usage: each request transaction carries one message byte on req_data_byte, with
// req_final_byte set on the last byte of a message. Each response transaction carries
// one ASCII character on rsp_code_char; rsp_end_mark is set on the last character of
// a message, after any '=' padding. A message of N bytes gives 4*ceil(N/3) characters.
// The front end accepts a byte and writes all of its characters (one to four) as
// one entry into a queue of QUEUE_DEPTH entries. The back end sends one character
// per cycle from the queue head through an output register while rsp_ready is high.
// A request's first character passes through the queue and then the output register.
// The single character output sets the sustained rate: a byte is done once all of its
// characters have been sent, while the queue lets the front end take further bytes
// before the earlier ones are done.
// When the receiver stalls, the output register holds its character and the queue
// fills; req_ready drops only once the queue is full.
// Reset clears the group phase, the leftover bits, the queue and the output valid flag.
module base64_stream_encoder import b64enc_pkg::*; #(
   parameter int QUEUE_DEPTH = B64_QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_final_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [6:0] rsp_code_char,
   output logic       rsp_end_mark
);

   q_stat_type q_stat;
   logic       push;
   entry_type  push_entry;
   logic       pop;
   entry_type  head;
   logic [1:0] char_idx;

   b64enc_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data_byte  (req_data_byte),
      .req_final_byte (req_final_byte),
      .q_stat         (q_stat),
      .push           (push),
      .push_entry     (push_entry)
   );

   b64enc_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .q_stat     (q_stat)
   );

   b64enc_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head          (head),
      .q_stat        (q_stat),
      .pop           (pop),
      .char_idx      (char_idx),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_code_char (rsp_code_char),
      .rsp_end_mark  (rsp_end_mark)
   );

   a_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_stat.empty)
      else $error("Queue popped while empty.");

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      !q_stat.empty |-> (char_idx <= head.last_idx))
      else $error("Character index passed the last character of the head entry.");

   a_idle_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && q_stat.empty && !rsp_valid) |-> ##2 rsp_valid)
      else $error("First character did not appear two cycles after an idle transaction.");

endmodule
